// File: hw/rtl/mcbm_pkg.sv
`timescale 1ns / 1ps
// mcbm_pkg: constants used by the minimum capacity matcher and its testbench
// no dependencies

package mcbm_pkg;

   localparam int DEF_MAX_LEFT  = 1024;
   localparam int DEF_MAX_RIGHT = 512;

   localparam int LEFT_NODE_W  = 10;
   localparam int RIGHT_NODE_W = 9;
   localparam int COUNT_W      = 11;

   localparam logic [COUNT_W-1:0] LEFT_COUNT_RESET = 11'd1;

endpackage

// File: hw/rtl/mcbm_ram.sv
`timescale 1ns / 1ps
// mcbm_ram: generic simple dual port ram, one write and one registered read
// read returns the old data on a same address write; no dependencies

module mcbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/min_capacity_bipartite_matcher.sv
`timescale 1ns / 1ps
// min_capacity_bipartite_matcher: edge loader, capacity binary search and
// augmenting path search over rams; uses mcbm_pkg and mcbm_ram
//
//   channel  dir  handshake                  payload
//   req      in   req_valid / req_ready      req_left_node, req_right_node, req_last
//   rsp      out  rsp_valid / rsp_ready      rsp_min_capacity
//   csr      in   csr_write_enable           csr_write_data (left_count)
//
// edges load one per cycle; the last edge starts the solve and req_ready stays low
// until the answer is registered and the adjacency ram is cleared.
// solve: an emptiness check per left node (S_CHK_RD, S_CHK_EV), then per trial a pass of
// right node clearing plus the depth first search: every row visit scans one right
// index per cycle, pausing to probe the occupant of each set bit and for every unwind step.
// after reset the adjacency clearing pass runs before req_ready rises.
// the answer waits in the output register while rsp_ready is low.

module min_capacity_bipartite_matcher #(
   parameter int MAX_LEFT  = mcbm_pkg::DEF_MAX_LEFT,
   parameter int MAX_RIGHT = mcbm_pkg::DEF_MAX_RIGHT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [mcbm_pkg::LEFT_NODE_W-1:0]   req_left_node,
   input  logic [mcbm_pkg::RIGHT_NODE_W-1:0]  req_right_node,
   input  logic                               req_last,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [mcbm_pkg::COUNT_W-1:0]       rsp_min_capacity,
   input  logic                               csr_write_enable,
   input  logic [mcbm_pkg::COUNT_W-1:0]       csr_write_data
);

   localparam int LW  = $clog2(MAX_LEFT);
   localparam int RW  = $clog2(MAX_RIGHT);
   localparam int CW  = $clog2(MAX_LEFT + 1);
   localparam int SPW = $clog2(MAX_RIGHT + 1);
   localparam int SW  = ((LW > RW) ? LW : RW) + 1;

   typedef struct packed {
      logic          v;
      logic [LW-1:0] idx;
   } ptr_type;

   typedef struct packed {
      logic [LW-1:0] p;
      logic [RW-1:0] q;
      ptr_type       o;
      ptr_type       pr;
      ptr_type       nx;
   } frame_type;

   typedef struct packed {
      logic [CW-1:0] load;
      logic [CW-1:0] stamp;
   } rstat_type;

   typedef enum logic [18:0] {
      S_CLRA   = 19'b0000000000000000001,
      S_LOAD   = 19'b0000000000000000010,
      S_CHK_RD = 19'b0000000000000000100,
      S_CHK_EV = 19'b0000000000000001000,
      S_BS     = 19'b0000000000000010000,
      S_CLRR   = 19'b0000000000000100000,
      S_ROOT   = 19'b0000000000001000000,
      S_ROW_RD = 19'b0000000000010000000,
      S_ROW_WT = 19'b0000000000100000000,
      S_SCAN   = 19'b0000000001000000000,
      S_RGT_WT = 19'b0000000010000000000,
      S_OCC    = 19'b0000000100000000000,
      S_OCC_WT = 19'b0000001000000000000,
      S_POP    = 19'b0000010000000000000,
      S_POP_WT = 19'b0000100000000000000,
      S_UNW    = 19'b0001000000000000000,
      S_UNW_WT = 19'b0010000000000000000,
      S_UNW2   = 19'b0100000000000000000,
      S_EMIT   = 19'b1000000000000000000
   } state_type;

   state_type state_ff, state_in;

   logic                             s1_v_ff, s1_v_in;
   logic                             s1_last_ff, s1_last_in;
   logic                             s1_ok_ff, s1_ok_in;
   logic [LW-1:0]                    s1_l_ff, s1_l_in;
   logic [RW-1:0]                    s1_r_ff, s1_r_in;
   logic                             fwd_v_ff, fwd_v_in;
   logic [LW-1:0]                    fwd_l_ff, fwd_l_in;
   logic [MAX_RIGHT-1:0]             fwd_row_ff, fwd_row_in;
   logic [mcbm_pkg::COUNT_W-1:0]     lc_ff, lc_in;
   logic [CW-1:0]                    n_ff, n_in;
   logic [CW-1:0]                    lo_ff, lo_in;
   logic [CW-1:0]                    hi_ff, hi_in;
   logic [CW-1:0]                    k_ff, k_in;
   logic [CW-1:0]                    root_ff, root_in;
   logic [LW-1:0]                    p_ff, p_in;
   logic [RW:0]                      j_ff, j_in;
   ptr_type                          o_ff, o_in;
   ptr_type                          pr_ff, pr_in;
   logic [SPW-1:0]                   sp_ff, sp_in;
   logic [MAX_RIGHT-1:0]             row_ff, row_in;
   logic                             resume_ff, resume_in;
   logic [SW-1:0]                    clr_ff, clr_in;
   logic                             rsp_v_ff, rsp_v_in;
   logic [mcbm_pkg::COUNT_W-1:0]     rsp_d_ff, rsp_d_in;

   logic                  adj_we;
   logic [LW-1:0]         adj_wa, adj_ra;
   logic [MAX_RIGHT-1:0]  adj_wd, adj_rd;
   logic                  nxt_we;
   logic [LW-1:0]         nxt_wa;
   ptr_type               nxt_wd, nxt_rd;
   logic                  head_we;
   logic [RW-1:0]         head_wa;
   ptr_type               head_wd, head_rd;
   logic                  rst_we;
   logic [RW-1:0]         rst_wa;
   rstat_type             rst_wd, rst_rd;
   logic                  stk_we;
   frame_type             stk_wd, stk_rd;

   logic                  req_fire;
   logic [MAX_RIGHT-1:0]  base_row;
   logic [CW-1:0]         eff_n;
   logic [CW-1:0]         cur_stamp;
   logic [CW:0]           lo_hi_sum;
   logic [RW-1:0]         cur_q;
   logic [RW-1:0]         sp_top;

   assign req_ready = (state_ff == S_LOAD) && !(s1_v_ff && s1_last_ff);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_v_ff;
   assign rsp_min_capacity = rsp_d_ff;

   assign base_row  = (fwd_v_ff && (fwd_l_ff == s1_l_ff)) ? fwd_row_ff : adj_rd;
   assign cur_stamp = root_ff + CW'(1);
   assign lo_hi_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign cur_q     = j_ff[RW-1:0];
   assign sp_top    = RW'(sp_ff - SPW'(1));

   always_comb begin
      if (lc_ff == '0) begin
         eff_n = CW'(1);
      end else if (32'(lc_ff) > MAX_LEFT) begin
         eff_n = CW'(MAX_LEFT);
      end else begin
         eff_n = CW'(lc_ff);
      end
   end

   always_comb begin
      state_in   = state_ff;
      s1_v_in    = 1'b0;
      s1_last_in = s1_last_ff;
      s1_ok_in   = s1_ok_ff;
      s1_l_in    = s1_l_ff;
      s1_r_in    = s1_r_ff;
      fwd_v_in   = fwd_v_ff;
      fwd_l_in   = fwd_l_ff;
      fwd_row_in = fwd_row_ff;
      lc_in      = csr_write_enable ? csr_write_data : lc_ff;
      n_in       = n_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      k_in       = k_ff;
      root_in    = root_ff;
      p_in       = p_ff;
      j_in       = j_ff;
      o_in       = o_ff;
      pr_in      = pr_ff;
      sp_in      = sp_ff;
      row_in     = row_ff;
      resume_in  = resume_ff;
      clr_in     = clr_ff;
      rsp_v_in   = rsp_v_ff && !rsp_ready;
      rsp_d_in   = rsp_d_ff;

      adj_we  = 1'b0;
      adj_wa  = s1_l_ff;
      adj_wd  = base_row | (MAX_RIGHT'(1) << s1_r_ff);
      adj_ra  = p_ff;
      nxt_we  = 1'b0;
      nxt_wa  = p_ff;
      nxt_wd  = head_rd;
      head_we = 1'b0;
      head_wa = cur_q;
      head_wd = '{v: 1'b1, idx: p_ff};
      rst_we  = 1'b0;
      rst_wa  = cur_q;
      rst_wd  = rst_rd;
      stk_we  = 1'b0;
      stk_wd  = '{p: p_ff, q: cur_q, o: o_ff, pr: pr_ff, nx: nxt_rd};

      case (state_ff)
         S_CLRA: begin
            fwd_v_in = 1'b0;
            adj_we   = 1'b1;
            adj_wa   = LW'(clr_ff);
            adj_wd   = '0;
            clr_in   = clr_ff + SW'(1);
            if (clr_ff == SW'(MAX_LEFT - 1)) begin
               clr_in   = '0;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            adj_ra = LW'(req_left_node);
            if (req_fire) begin
               s1_v_in    = 1'b1;
               s1_last_in = req_last;
               s1_ok_in   = (32'(req_left_node) < MAX_LEFT) &&
                            (32'(req_right_node) < MAX_RIGHT);
               s1_l_in    = LW'(req_left_node);
               s1_r_in    = RW'(req_right_node);
            end
            if (s1_v_ff) begin
               if (s1_ok_ff) begin
                  adj_we     = 1'b1;
                  fwd_v_in   = 1'b1;
                  fwd_l_in   = s1_l_ff;
                  fwd_row_in = adj_wd;
               end
               if (s1_last_ff) begin
                  n_in     = eff_n;
                  root_in  = '0;
                  state_in = S_CHK_RD;
               end
            end
         end
         S_CHK_RD: begin
            adj_ra = LW'(root_ff);
            if (root_ff == n_ff) begin
               lo_in    = '0;
               hi_in    = n_ff;
               state_in = S_BS;
            end else begin
               state_in = S_CHK_EV;
            end
         end
         S_CHK_EV: begin
            if (adj_rd == '0) begin
               hi_in    = n_ff;
               state_in = S_EMIT;
            end else begin
               root_in  = root_ff + CW'(1);
               state_in = S_CHK_RD;
            end
         end
         S_BS: begin
            if (({1'b0, lo_ff} + (CW+1)'(1)) < {1'b0, hi_ff}) begin
               k_in     = CW'(lo_hi_sum >> 1);
               clr_in   = '0;
               state_in = S_CLRR;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_CLRR: begin
            rst_we  = 1'b1;
            rst_wa  = RW'(clr_ff);
            rst_wd  = '0;
            head_we = 1'b1;
            head_wa = RW'(clr_ff);
            head_wd = '0;
            clr_in  = clr_ff + SW'(1);
            if (clr_ff == SW'(MAX_RIGHT - 1)) begin
               clr_in   = '0;
               root_in  = '0;
               state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            if (root_ff == n_ff) begin
               hi_in    = k_ff;
               state_in = S_BS;
            end else begin
               p_in      = LW'(root_ff);
               j_in      = '0;
               sp_in     = '0;
               resume_in = 1'b0;
               state_in  = S_ROW_RD;
            end
         end
         S_ROW_RD: begin
            state_in = S_ROW_WT;
         end
         S_ROW_WT: begin
            row_in   = adj_rd;
            state_in = resume_ff ? S_OCC : S_SCAN;
         end
         S_SCAN: begin
            if (j_ff == (RW+1)'(MAX_RIGHT)) begin
               state_in = S_POP;
            end else if (!row_ff[cur_q]) begin
               j_in = j_ff + (RW+1)'(1);
            end else begin
               state_in = S_RGT_WT;
            end
         end
         S_RGT_WT: begin
            if (rst_rd.load < k_ff) begin
               rst_we       = 1'b1;
               rst_wd.load  = rst_rd.load + CW'(1);
               head_we      = 1'b1;
               nxt_we       = 1'b1;
               state_in     = S_UNW;
            end else if (rst_rd.stamp == cur_stamp) begin
               j_in     = j_ff + (RW+1)'(1);
               state_in = S_SCAN;
            end else begin
               rst_we       = 1'b1;
               rst_wd.stamp = cur_stamp;
               o_in         = head_rd;
               pr_in        = '0;
               state_in     = S_OCC;
            end
         end
         S_OCC: begin
            if (!o_ff.v) begin
               j_in     = j_ff + (RW+1)'(1);
               state_in = S_SCAN;
            end else begin
               state_in = S_OCC_WT;
            end
         end
         S_OCC_WT: begin
            stk_we    = 1'b1;
            sp_in     = sp_ff + SPW'(1);
            p_in      = o_ff.idx;
            j_in      = '0;
            resume_in = 1'b0;
            state_in  = S_ROW_RD;
         end
         S_POP: begin
            if (sp_ff == '0) begin
               lo_in    = k_ff;
               state_in = S_BS;
            end else begin
               sp_in    = sp_ff - SPW'(1);
               state_in = S_POP_WT;
            end
         end
         S_POP_WT: begin
            p_in      = stk_rd.p;
            j_in      = {1'b0, stk_rd.q};
            pr_in     = stk_rd.o;
            o_in      = stk_rd.nx;
            resume_in = 1'b1;
            state_in  = S_ROW_RD;
         end
         S_UNW: begin
            if (sp_ff == '0) begin
               root_in  = root_ff + CW'(1);
               state_in = S_ROOT;
            end else begin
               sp_in    = sp_ff - SPW'(1);
               state_in = S_UNW_WT;
            end
         end
         S_UNW_WT: begin
            p_in     = stk_rd.p;
            j_in     = {1'b0, stk_rd.q};
            pr_in    = stk_rd.pr;
            nxt_we   = 1'b1;
            nxt_wa   = stk_rd.p;
            nxt_wd   = stk_rd.nx;
            state_in = S_UNW2;
         end
         S_UNW2: begin
            if (pr_ff.v) begin
               nxt_we = 1'b1;
               nxt_wa = pr_ff.idx;
               nxt_wd = '{v: 1'b1, idx: p_ff};
            end else begin
               head_we = 1'b1;
            end
            state_in = S_UNW;
         end
         S_EMIT: begin
            if (!rsp_v_ff || rsp_ready) begin
               rsp_v_in = 1'b1;
               rsp_d_in = mcbm_pkg::COUNT_W'(hi_ff);
               clr_in   = '0;
               state_in = S_CLRA;
            end
         end
         default: begin
            state_in = S_CLRA;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLRA;
         s1_v_ff   <= 1'b0;
         fwd_v_ff  <= 1'b0;
         lc_ff     <= mcbm_pkg::LEFT_COUNT_RESET;
         clr_ff    <= '0;
         rsp_v_ff  <= 1'b0;
         sp_ff     <= '0;
         resume_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         s1_v_ff   <= s1_v_in;
         fwd_v_ff  <= fwd_v_in;
         lc_ff     <= lc_in;
         clr_ff    <= clr_in;
         rsp_v_ff  <= rsp_v_in;
         sp_ff     <= sp_in;
         resume_ff <= resume_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_last_ff <= s1_last_in;
      s1_ok_ff   <= s1_ok_in;
      s1_l_ff    <= s1_l_in;
      s1_r_ff    <= s1_r_in;
      fwd_l_ff   <= fwd_l_in;
      fwd_row_ff <= fwd_row_in;
      n_ff       <= n_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      k_ff       <= k_in;
      root_ff    <= root_in;
      p_ff       <= p_in;
      j_ff       <= j_in;
      o_ff       <= o_in;
      pr_ff      <= pr_in;
      row_ff     <= row_in;
      rsp_d_ff   <= rsp_d_in;
   end

   mcbm_ram #(.WIDTH(MAX_RIGHT), .DEPTH(MAX_LEFT)) u_adj_ram (
      .clock   (clock),
      .wr_en   (adj_we),
      .wr_addr (adj_wa),
      .wr_data (adj_wd),
      .rd_addr (adj_ra),
      .rd_data (adj_rd)
   );

   mcbm_ram #(.WIDTH($bits(ptr_type)), .DEPTH(MAX_LEFT)) u_next_ram (
      .clock   (clock),
      .wr_en   (nxt_we),
      .wr_addr (nxt_wa),
      .wr_data (nxt_wd),
      .rd_addr (o_ff.idx),
      .rd_data (nxt_rd)
   );

   mcbm_ram #(.WIDTH($bits(ptr_type)), .DEPTH(MAX_RIGHT)) u_head_ram (
      .clock   (clock),
      .wr_en   (head_we),
      .wr_addr (head_wa),
      .wr_data (head_wd),
      .rd_addr (cur_q),
      .rd_data (head_rd)
   );

   mcbm_ram #(.WIDTH($bits(rstat_type)), .DEPTH(MAX_RIGHT)) u_rstat_ram (
      .clock   (clock),
      .wr_en   (rst_we),
      .wr_addr (rst_wa),
      .wr_data (rst_wd),
      .rd_addr (cur_q),
      .rd_data (rst_rd)
   );

   mcbm_ram #(.WIDTH($bits(frame_type)), .DEPTH(MAX_RIGHT)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (RW'(sp_ff)),
      .wr_data (stk_wd),
      .rd_addr (sp_top),
      .rd_data (stk_rd)
   );

endmodule

// File: tb/min_capacity_bipartite_matcher_tb.sv
`timescale 1ns / 1ps
// min_capacity_bipartite_matcher_tb: loads edge beats, predicts the minimum right node
// capacity per graph and checks every answer beat; depends on mcbm_pkg and the matcher rtl

module min_capacity_bipartite_matcher_tb;

   localparam int LEFT_NODE_W  = mcbm_pkg::LEFT_NODE_W;
   localparam int RIGHT_NODE_W = mcbm_pkg::RIGHT_NODE_W;
   localparam int COUNT_W      = mcbm_pkg::COUNT_W;
   localparam int N_LEFT       = mcbm_pkg::DEF_MAX_LEFT;
   localparam int N_RIGHT      = mcbm_pkg::DEF_MAX_RIGHT;

   typedef enum logic [1:0] {ITEM_EDGE, ITEM_CSR, ITEM_DRAIN} item_kind_type;

   typedef struct {
      item_kind_type           kind;
      logic [LEFT_NODE_W-1:0]  left_node;
      logic [RIGHT_NODE_W-1:0] right_node;
      logic                    last;
      logic [COUNT_W-1:0]      count;
   } pending_item_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [LEFT_NODE_W-1:0]  req_left_node;
   logic [RIGHT_NODE_W-1:0] req_right_node;
   logic                    req_last;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic [COUNT_W-1:0]      rsp_min_capacity;
   logic                    csr_write_enable;
   logic [COUNT_W-1:0]      csr_write_data;

   pending_item_type   pending_items[$];
   logic [COUNT_W-1:0] expected_capacity[$];
   int                 mismatches;
   int                 sender_gap;
   int                 receiver_stall;
   bit                 sender_idles;
   bit                 receiver_idles;
   int                 edge_total;

   // predictor state
   bit                 edge_seen[N_LEFT][N_RIGHT];
   int                 neighbors[N_LEFT][$];
   int                 touched_left[$];
   logic [COUNT_W-1:0] model_left_count;
   int                 match_of[N_LEFT];
   int                 right_load[N_RIGHT];
   int                 came_from[N_RIGHT];
   bit                 right_seen[N_RIGHT];

   min_capacity_bipartite_matcher dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_left_node    (req_left_node),
      .req_right_node   (req_right_node),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_min_capacity (rsp_min_capacity),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // bfs augmenting search, right nodes hold up to cap left nodes
   function automatic bit capacity_fits(int n, int cap);
      int frontier[$];
      int x, v, w, found, prev;
      for (v = 0; v < N_RIGHT; v++) right_load[v] = 0;
      for (x = 0; x < n; x++) match_of[x] = -1;
      for (int u = 0; u < n; u++) begin
         for (v = 0; v < N_RIGHT; v++) right_seen[v] = 0;
         frontier = {u};
         found = -1;
         while (frontier.size() > 0 && found < 0) begin
            x = frontier.pop_front();
            foreach (neighbors[x][i]) begin
               v = neighbors[x][i];
               if (!right_seen[v]) begin
                  right_seen[v] = 1;
                  came_from[v] = x;
                  if (right_load[v] < cap) begin
                     found = v;
                     break;
                  end
                  for (w = 0; w < u; w++)
                     if (match_of[w] == v) frontier.push_back(w);
               end
            end
         end
         if (found < 0) return 0;
         v = found;
         forever begin
            x = came_from[v];
            prev = match_of[x];
            match_of[x] = v;
            right_load[v]++;
            if (prev < 0) break;
            right_load[prev]--;
            v = prev;
         end
      end
      return 1;
   endfunction

   function automatic logic [COUNT_W-1:0] min_capacity_of_graph();
      int n, lo, hi, mid;
      n = int'(model_left_count);
      if (n == 0) n = 1;
      if (n > N_LEFT) n = N_LEFT;
      for (int p = 0; p < n; p++)
         if (neighbors[p].size() == 0) return COUNT_W'(n);
      lo = 0;
      hi = n;
      while (lo + 1 < hi) begin
         mid = (lo + hi) / 2;
         if (capacity_fits(n, mid)) hi = mid;
         else lo = mid;
      end
      return COUNT_W'(hi);
   endfunction

   function automatic void store_edge(int l, int r, bit last);
      if (!edge_seen[l][r]) begin
         edge_seen[l][r] = 1;
         if (neighbors[l].size() == 0) touched_left.push_back(l);
         neighbors[l].push_back(r);
      end
      if (last) begin
         expected_capacity.push_back(min_capacity_of_graph());
         foreach (touched_left[i]) begin
            foreach (neighbors[touched_left[i]][j])
               edge_seen[touched_left[i]][neighbors[touched_left[i]][j]] = 0;
            neighbors[touched_left[i]].delete();
         end
         touched_left.delete();
      end
   endfunction

   function automatic void add_edge(int l, int r, bit last);
      pending_item_type it;
      it.kind = ITEM_EDGE;
      it.left_node = LEFT_NODE_W'(l);
      it.right_node = RIGHT_NODE_W'(r);
      it.last = last;
      it.count = '0;
      pending_items.push_back(it);
      edge_total++;
   endfunction

   function automatic void add_marker(item_kind_type kind, int count);
      pending_item_type it;
      it.kind = kind;
      it.left_node = '0;
      it.right_node = '0;
      it.last = 1'b0;
      it.count = COUNT_W'(count);
      pending_items.push_back(it);
   endfunction

   function automatic int draw_gap(bit idles);
      return idles ? $urandom_range(0, 14) : 0;
   endfunction

   // count that will be in force when the next graph is loaded
   function automatic int model_left_count_planned();
      int c;
      c = int'(mcbm_pkg::LEFT_COUNT_RESET);
      foreach (pending_items[i])
         if (pending_items[i].kind == ITEM_CSR) c = int'(pending_items[i].count);
      if (c == 0) c = 1;
      if (c > 40) c = 40;
      return c;
   endfunction

   // driver: edge beats, register writes once idle, drain pauses
   always @(posedge clock) begin
      logic             valid_next;
      logic             we_next;
      int               gap;
      pending_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
         csr_write_enable <= 1'b0;
         sender_gap <= 0;
      end else begin
         valid_next = req_valid;
         we_next = 1'b0;
         gap = sender_gap;
         if (req_valid && req_ready) begin
            store_edge(int'(req_left_node), int'(req_right_node), req_last);
            valid_next = 1'b0;
            gap = draw_gap(sender_idles);
            if (req_last && $urandom_range(0, 3) == 0) sender_idles = !sender_idles;
         end else if (!req_valid && gap > 0) begin
            gap--;
         end
         if (!valid_next && gap == 0 && pending_items.size() > 0) begin
            it = pending_items[0];
            case (it.kind)
               ITEM_EDGE: begin
                  valid_next = 1'b1;
                  req_left_node <= it.left_node;
                  req_right_node <= it.right_node;
                  req_last <= it.last;
                  void'(pending_items.pop_front());
               end
               ITEM_CSR: begin
                  if (expected_capacity.size() == 0 && req_ready && !csr_write_enable) begin
                     we_next = 1'b1;
                     csr_write_data <= it.count;
                     model_left_count = it.count;
                     void'(pending_items.pop_front());
                  end
               end
               default: begin
                  if (expected_capacity.size() == 0) void'(pending_items.pop_front());
               end
            endcase
         end
         req_valid <= valid_next;
         csr_write_enable <= we_next;
         sender_gap <= gap;
      end
   end

   // monitor: answer beats against the oldest prediction
   always @(posedge clock) begin
      logic [COUNT_W-1:0] want;
      int                 stall;
      if (reset) begin
         rsp_ready <= 1'b0;
         receiver_stall <= 0;
      end else begin
         stall = receiver_stall;
         if (rsp_valid && rsp_ready) begin
            if (expected_capacity.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected answer beat: min_capacity %0d", rsp_min_capacity);
            end else begin
               want = expected_capacity.pop_front();
               if (rsp_min_capacity !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("min_capacity mismatch: expected %0d actual %0d",
                              want, rsp_min_capacity);
               end
            end
            stall = draw_gap(receiver_idles);
            if ($urandom_range(0, 7) == 0) receiver_idles = !receiver_idles;
         end else if (stall > 0) begin
            stall--;
         end
         rsp_ready <= (stall == 0);
         receiver_stall <= stall;
      end
   end

   initial begin
      repeat (20) #100_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      int n, span, base, edges, l;
      req_valid = 1'b0;
      req_left_node = '0;
      req_right_node = '0;
      req_last = 1'b0;
      rsp_ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      mismatches = 0;
      sender_idles = 1;
      receiver_idles = 1;
      edge_total = 0;
      model_left_count = mcbm_pkg::LEFT_COUNT_RESET;

      // directed graphs
      add_edge(0, 0, 1);                            // reset count, single left node
      add_marker(ITEM_CSR, 0);                      // count zero acts as one
      add_edge(1023, 511, 1);
      add_marker(ITEM_CSR, 3);                      // all on one right node
      add_edge(0, 5, 0); add_edge(1, 5, 0); add_edge(2, 5, 1);
      add_edge(0, 0, 0); add_edge(1, 1, 0); add_edge(2, 2, 0);
      add_edge(2, 2, 0); add_edge(1023, 511, 1);    // duplicate edge, unused left
      add_marker(ITEM_CSR, 4);
      add_edge(0, 0, 0); add_edge(0, 1, 0); add_edge(1, 0, 0);
      add_edge(2, 0, 0); add_edge(3, 1, 1);
      add_marker(ITEM_CSR, 1024);                   // largest count, empty left nodes
      add_edge(0, 0, 1);
      add_marker(ITEM_CSR, 2047);                   // saturates
      add_edge(5, 5, 1);
      add_marker(ITEM_CSR, 2);                      // left node 0 without edges
      add_edge(1, 3, 1);
      add_marker(ITEM_DRAIN, 0);

      // random graphs
      while (edge_total < 1450) begin
         if ($urandom_range(0, 9) < 7) begin
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
            add_marker(ITEM_CSR, n);
         end else begin
            n = model_left_count_planned();
         end
         span = ($urandom_range(0, 4) == 0) ? N_RIGHT : $urandom_range(1, n + 2);
         base = $urandom_range(0, N_RIGHT - span);
         edges = n * $urandom_range(1, 3);
         for (int e = 0; e < edges; e++) begin
            if ($urandom_range(0, 19) == 0) begin
               add_edge($urandom_range(0, N_LEFT - 1), $urandom_range(0, N_RIGHT - 1), 0);
            end else begin
               l = (e < n && $urandom_range(0, 19) != 0) ? e : $urandom_range(0, n - 1);
               add_edge(l, base + $urandom_range(0, span - 1), 0);
            end
         end
         add_edge($urandom_range(0, n - 1), base + $urandom_range(0, span - 1), 1);
         if ($urandom_range(0, 19) == 0) add_marker(ITEM_DRAIN, 0);
      end

      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending_items.size() > 0 || req_valid || expected_capacity.size() > 0)
         @(posedge clock);
      repeat (2000) @(posedge clock);
      if (mismatches == 0 && expected_capacity.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
